/* rtl/bwcb_pkg.sv */
// ----------------------------------------------------------------------------
// bwcb_pkg: shared types and constants for the block write coverage bitmap
// Holds mode codes, default widths and the divider request and response structs.
// ----------------------------------------------------------------------------
package bwcb_pkg;

  localparam int unsigned MaxBlocksDefault = 4096;
  localparam int unsigned BsWidth = 21;
  localparam int unsigned FieldWidth = 31;
  localparam int unsigned LenWidth = 32;
  localparam int unsigned CalcWidth = 34;
  localparam logic [BsWidth-1:0] BsReset = 21'd4096;

  localparam logic [2:0] ModeWrite = 3'd0;
  localparam logic [2:0] ModeCheck = 3'd1;
  localparam logic [2:0] ModeTrunc = 3'd2;
  localparam logic [2:0] ModeSetLen = 3'd3;
  localparam logic [2:0] ModeFull = 3'd4;

  // Divider request and response between sequencer and divider
  typedef struct packed {
    logic                 start;
    logic [CalcWidth-1:0] dividend;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [CalcWidth-1:0] quot;
    logic [CalcWidth-1:0] rem;
  } div_rsp_t;

endpackage

/* rtl/bwcb_div.sv */
// ----------------------------------------------------------------------------
// bwcb_div: radix-2 restoring divider
// Divides an unsigned value by the block size, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bwcb_div import bwcb_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic [BsWidth-1:0] divisor,
  input  div_req_t           req,
  output div_rsp_t           rsp
);

  localparam int unsigned CntW = $clog2(CalcWidth + 1);

  logic [CalcWidth-1:0] quot;
  logic [CalcWidth-1:0] rem;
  logic [CntW-1:0]      cnt;
  logic                 busy;
  logic                 done;
  logic [CalcWidth:0]   trial;
  logic [CalcWidth-1:0] dvs;

  assign dvs   = (divisor == '0) ? CalcWidth'(1) : CalcWidth'(divisor);
  assign trial = {rem, quot[CalcWidth-1]} - {1'b0, dvs};

  // Shift one bit per cycle, subtract when it fits
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      if (req.start) begin
        busy <= 1'b1;
        done <= 1'b0;
        cnt  <= CntW'(CalcWidth);
        quot <= req.dividend;
        rem  <= '0;
      end else if (busy) begin
        if (!trial[CalcWidth]) begin
          rem <= trial[CalcWidth-1:0];
        end else begin
          rem <= {rem[CalcWidth-2:0], quot[CalcWidth-1]};
        end
        quot <= {quot[CalcWidth-2:0], ~trial[CalcWidth]};
        cnt  <= cnt - 1'b1;
        if (cnt == CntW'(1)) begin
          busy <= 1'b0;
        end
        done <= (cnt == CntW'(1));
      end else begin
        done <= 1'b0;
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quot = quot;
  assign rsp.rem  = rem;

endmodule

/* rtl/bwcb_bitmap.sv */
// ----------------------------------------------------------------------------
// bwcb_bitmap: valid bit store
// One synchronous memory, one bit per block.
// ----------------------------------------------------------------------------
module bwcb_bitmap import bwcb_pkg::*; #(
  parameter int unsigned MaxBlocks = MaxBlocksDefault,
  parameter int unsigned AddrW = $clog2(MaxBlocks)
) (
  input  logic             clk,
  input  logic [AddrW-1:0] raddr,
  output logic             rdata,
  input  logic             we,
  input  logic [AddrW-1:0] waddr,
  input  logic             wdata
);

  logic mem [MaxBlocks];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/block_write_coverage_bitmap_top.sv */
// ----------------------------------------------------------------------------
// block_write_coverage_bitmap_top: tracks fully written blocks of a file
// Sequencer over a bit-per-block memory with a shared serial divider.
// ----------------------------------------------------------------------------
// Usage:
//   Input items arrive on s_axis (tdata: mode, offset, size, new_length).
//   One result per item leaves on m_axis (tdata: ok, file_length).
//   block_size, written via cfg_we / cfg_data, is kept to idle by the user alone.
// Sequencing:
//   One item at a time. Each division by the block size goes through the
//   serial divider (up to five per item). Each block walked takes a read
//   state and then a write or check state at the memory port; tail cleanup
//   walks from the first block past the length up to MaxBlocks. A check
//   walks its range.
// Reset:
//   A clearing sweep writes zero to all MaxBlocks entries, one per cycle,
//   while s_axis_tready stays low. Length and run state clear at once.
// Stall:
//   The result is held in the ok and file_len registers until m_axis_tready; the
//   sequencer waits there, so s_axis_tready stays low meanwhile.
// ----------------------------------------------------------------------------
module block_write_coverage_bitmap_top import bwcb_pkg::*; #(
  parameter int unsigned MaxBlocks = MaxBlocksDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [BsWidth-1:0] cfg_data,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  // mode[2:0], offset[33:3], size[64:34], new_length[95:65]
  input  logic [95:0]        s_axis_tdata,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // ok[0], file_length[32:1], zero pad above
  output logic [39:0]        m_axis_tdata
);

  localparam int unsigned AddrW = $clog2(MaxBlocks);
  localparam logic [CalcWidth-1:0] MaxBlk = CalcWidth'(MaxBlocks);

  typedef enum logic [17:0] {
    S_CLR    = 18'h00001,
    S_IDLE   = 18'h00002,
    S_DISP   = 18'h00004,
    S_W0     = 18'h00008,
    S_W1     = 18'h00010,
    S_W2     = 18'h00020,
    S_MARK   = 18'h00040,
    S_W3     = 18'h00080,
    S_PUTRD  = 18'h00100,
    S_PUTWR  = 18'h00200,
    S_TAIL0  = 18'h00400,
    S_TAILRD = 18'h00800,
    S_TAILWR = 18'h01000,
    S_CK0    = 18'h02000,
    S_CK1    = 18'h04000,
    S_CKRD   = 18'h08000,
    S_CKCHK  = 18'h10000,
    S_OUT    = 18'h20000
  } state_t;

  typedef enum logic [1:0] {
    P_FIRST = 2'd0,
    P_LAST  = 2'd1,
    P_DONE  = 2'd2
  } put_t;

  state_t state;
  put_t   put_ret;

  logic [BsWidth-1:0]   block_size;
  logic [LenWidth-1:0]  file_len;
  logic                 run_active;
  logic [CalcWidth-1:0] run_begin;
  logic [CalcWidth-1:0] run_end;
  logic                 changed;

  logic [2:0]            mode;
  logic [CalcWidth-1:0]  w_off;
  logic [CalcWidth-1:0]  w_size;
  logic [FieldWidth-1:0] nlen;
  logic                  ok;
  logic                  do_tail;
  logic                  put_val;
  logic [CalcWidth-1:0]  put_blk;
  logic [CalcWidth-1:0]  cur;
  logic [CalcWidth-1:0]  stop;
  logic [CalcWidth-1:0]  bs_ext;
  logic [CalcWidth-1:0]  rnd_up;

  logic [AddrW-1:0] raddr;
  logic [AddrW-1:0] waddr;
  logic             rdata;
  logic             we;
  logic             wdata;

  div_req_t dreq;
  div_rsp_t drsp;

  logic [39:0] out_data;

  assign bs_ext = (block_size == '0) ? CalcWidth'(1) : CalcWidth'(block_size);

  // Run start rounded up to the next block boundary (remainder is nonzero)
  assign rnd_up = run_begin - drsp.rem + bs_ext;

  bwcb_div u_div (
    .clk     (clk),
    .rst     (rst),
    .divisor (block_size),
    .req     (dreq),
    .rsp     (drsp)
  );

  bwcb_bitmap #(.MaxBlocks(MaxBlocks), .AddrW(AddrW)) u_bitmap (
    .clk   (clk),
    .raddr (raddr),
    .rdata (rdata),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata)
  );

  // Memory addresses follow the current walk pointer, or put_blk in the put states
  always_comb begin
    raddr = cur[AddrW-1:0];
    if (state == S_PUTRD || state == S_PUTWR) begin
      raddr = put_blk[AddrW-1:0];
    end
    waddr = raddr;
    wdata = 1'b0;
    we    = 1'b0;
    unique case (state)
      S_CLR: we = 1'b1;
      S_PUTWR: begin
        wdata = put_val;
        we    = (rdata != put_val);
      end
      S_TAILWR: we = rdata;
      default: we = 1'b0;
    endcase
  end

  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = (state == S_OUT);
  assign m_axis_tdata  = out_data;

  // Sequencer
  always_ff @(posedge clk) begin
    logic go;
    go = 1'b0;
    if (rst) begin
      state      <= S_CLR;
      block_size <= BsReset;
      file_len   <= '0;
      run_active <= 1'b0;
      run_begin  <= '0;
      run_end    <= '0;
      changed    <= 1'b0;
      cur        <= '0;
      dreq       <= '0;
      put_ret    <= P_DONE;
    end else begin
      if (cfg_we) begin
        block_size <= cfg_data;
      end
      unique case (state)
        // sweep the memory clear after reset
        S_CLR: begin
          cur <= cur + 1'b1;
          if (cur == MaxBlk - 1'b1) begin
            state <= S_IDLE;
          end
        end
        // take an item
        S_IDLE: begin
          if (s_axis_tvalid) begin
            mode   <= s_axis_tdata[2:0];
            w_off  <= CalcWidth'(s_axis_tdata[33:3]);
            w_size <= CalcWidth'(s_axis_tdata[64:34]);
            nlen   <= s_axis_tdata[95:65];
            state  <= S_DISP;
          end
        end
        S_DISP: begin
          ok      <= 1'b1;
          do_tail <= 1'b0;
          unique case (mode)
            ModeWrite: state <= S_W0;
            ModeCheck: state <= S_CK0;
            ModeTrunc: begin
              if (CalcWidth'(nlen) > CalcWidth'(file_len)) begin
                w_off  <= CalcWidth'(file_len);
                w_size <= CalcWidth'(nlen) - CalcWidth'(file_len);
                state  <= S_W0;
              end else begin
                file_len <= LenWidth'(nlen);
                state    <= S_TAIL0;
              end
            end
            ModeSetLen: begin
              file_len <= LenWidth'(nlen);
              state    <= S_TAIL0;
            end
            ModeFull: begin
              w_off  <= '0;
              w_size <= CalcWidth'(file_len);
              state  <= S_CK0;
            end
            default: begin
              ok    <= 1'b0;
              state <= S_OUT;
            end
          endcase
        end
        // run update, then divide file_len for the hole clear
        S_W0: begin
          run_active <= 1'b1;
          if (!run_active || run_end != w_off) begin
            run_begin <= w_off;
          end
          run_end  <= w_off + w_size;
          go = 1'b1;
          dreq.dividend <= CalcWidth'(file_len);
          state <= S_W1;
        end
        S_W1: begin
          if (drsp.done) begin
            if (run_begin > CalcWidth'(file_len)) begin
              put_blk <= drsp.quot;
              put_val <= 1'b0;
              put_ret <= P_FIRST;
              state   <= S_PUTRD;
            end else begin
              go = 1'b1;
              dreq.dividend <= run_begin;
              state         <= S_W2;
            end
          end
        end
        // divide run_begin by the block size
        S_W2: begin
          if (drsp.done) begin
            if (drsp.rem != '0) begin
              if (rnd_up >= run_end) begin
                run_begin <= run_end;
                if (run_end > CalcWidth'(file_len)) begin
                  file_len <= LenWidth'(run_end);
                end
                state <= S_TAIL0;
                do_tail <= 1'b1;
              end else begin
                run_begin <= rnd_up;
                cur       <= drsp.quot + 1'b1;
                go = 1'b1;
                dreq.dividend <= run_end - rnd_up;
                state     <= S_MARK;
              end
            end else begin
              cur           <= drsp.quot;
              go = 1'b1;
              dreq.dividend <= run_end - run_begin;
              state         <= S_MARK;
            end
          end
        end
        // n = (run_end - run_begin) / bs, begin walking
        S_MARK: begin
          if (drsp.done) begin
            stop <= ((cur + drsp.quot) > MaxBlk) ? MaxBlk : cur + drsp.quot;
            run_begin <= run_end - drsp.rem;
            put_val   <= 1'b1;
            put_ret   <= P_LAST;
            put_blk   <= cur;
            if (cur >= ((cur + drsp.quot) > MaxBlk ? MaxBlk : cur + drsp.quot)) begin
              state <= S_W3;
            end else begin
              state <= S_PUTRD;
            end
          end
        end
        // grow the length and mark the block holding the last byte
        S_W3: begin
          if (put_ret == P_LAST && run_end >= CalcWidth'(file_len)) begin
            file_len <= LenWidth'(run_end);
            if (run_end != '0) begin
              go = 1'b1;
              dreq.dividend <= run_end - 1'b1;
              put_ret       <= P_DONE;
            end else begin
              do_tail <= 1'b1;
              state   <= S_TAIL0;
            end
          end else if (put_ret == P_LAST) begin
            do_tail <= 1'b1;
            state   <= S_TAIL0;
          end else if (drsp.done) begin
            put_blk <= drsp.quot;
            put_val <= 1'b1;
            state   <= S_PUTRD;
          end
        end
        // read-modify-write of one bit
        S_PUTRD: begin
          if (put_blk < MaxBlk) begin
            state <= S_PUTWR;
          end else if (put_ret == P_FIRST) begin
            go = 1'b1;
            dreq.dividend <= run_begin;
            state         <= S_W2;
          end else begin
            do_tail <= 1'b1;
            state   <= S_TAIL0;
          end
        end
        S_PUTWR: begin
          if (rdata != put_val) begin
            changed <= 1'b1;
          end
          unique case (put_ret)
            P_FIRST: begin
              go = 1'b1;
              dreq.dividend <= run_begin;
              state         <= S_W2;
            end
            P_LAST: begin
              if (put_blk + 1'b1 < stop) begin
                put_blk <= put_blk + 1'b1;
                cur     <= put_blk + 1'b1;
                state   <= S_PUTRD;
              end else begin
                state <= S_W3;
              end
            end
            default: begin
              do_tail <= 1'b1;
              state   <= S_TAIL0;
            end
          endcase
        end
        // tail clear from ceil(len / bs)
        S_TAIL0: begin
          if (!dreq.start && !drsp.done && cur != '1) begin
            if ((mode == ModeWrite) && !(changed && do_tail) && do_tail) begin
              state <= S_OUT;
            end else if ((mode == ModeWrite) && !do_tail) begin
              state <= S_OUT;
            end else begin
              go = 1'b1;
              dreq.dividend <= CalcWidth'(file_len) + bs_ext - 1'b1;
              cur           <= '1;
            end
          end else if (drsp.done) begin
            if (drsp.quot >= MaxBlk) begin
              state <= S_OUT;
            end else begin
              cur   <= drsp.quot;
              state <= S_TAILRD;
            end
          end
        end
        S_TAILRD: state <= S_TAILWR;
        S_TAILWR: begin
          if (rdata) begin
            changed <= 1'b1;
          end
          if (cur + 1'b1 >= MaxBlk) begin
            state <= S_OUT;
          end else begin
            cur   <= cur + 1'b1;
            state <= S_TAILRD;
          end
        end
        // range check: first block, last block, then walk
        S_CK0: begin
          if (w_size == '0) begin
            state <= S_OUT;
          end else begin
            go = 1'b1;
            dreq.dividend <= w_off;
            put_ret       <= P_FIRST;
            state         <= S_CK1;
          end
        end
        S_CK1: begin
          if (drsp.done) begin
            if (put_ret == P_FIRST) begin
              cur           <= drsp.quot;
              go = 1'b1;
              dreq.dividend <= w_off + w_size - 1'b1;
              put_ret       <= P_LAST;
            end else begin
              stop  <= drsp.quot;
              state <= S_CKRD;
            end
          end
        end
        S_CKRD: begin
          if (cur >= MaxBlk) begin
            ok    <= 1'b0;
            state <= S_OUT;
          end else begin
            state <= S_CKCHK;
          end
        end
        S_CKCHK: begin
          if (!rdata) begin
            ok    <= 1'b0;
            state <= S_OUT;
          end else if (cur >= stop) begin
            ok    <= (CalcWidth'(file_len) >= w_off + w_size);
            state <= S_OUT;
          end else begin
            cur   <= cur + 1'b1;
            state <= S_CKRD;
          end
        end
        S_OUT: begin
          cur <= '0;
          if (m_axis_tready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      dreq.start <= go;
    end
  end

  assign out_data = {7'd0, file_len, ok};

endmodule

/* rtl/bwcb_checker.sv */
// ----------------------------------------------------------------------------
// bwcb_checker: port-level checks for the coverage bitmap
// Watches handshakes, result stability and padding on the top level's ports.
// ----------------------------------------------------------------------------
module bwcb_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata
);

  // A held result keeps its value
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // No new input while a result waits
  a_excl: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("input ready while result pending");

  // Accepted item yields no result in the next cycle
  a_lat: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !m_axis_tvalid)
    else $error("result too early");

  // Padding stays zero
  a_pad: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[39:33] == 7'd0)
    else $error("pad bits set");

endmodule

bind block_write_coverage_bitmap_top bwcb_checker u_chk (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
